// File: rtl/core/pulse_width_single_wire_transmitter_top_macros.svh
// Assertion macros for the pulse-width transmitter checker.
// Each macro expects clk and rst_n in scope.
`ifndef PULSE_WIDTH_SINGLE_WIRE_TRANSMITTER_TOP_MACROS_SVH
`define PULSE_WIDTH_SINGLE_WIRE_TRANSMITTER_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PWT_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PWT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/pwt_pkg.sv
`timescale 1ns / 1ps

package pwt_pkg;

    // Item kinds
    localparam logic KIND_TICK = 1'b0;
    localparam logic KIND_LOAD = 1'b1;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_START_LOW = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SHORT     = 2'd2;

    // Reset values of the timing registers
    localparam logic [15:0] START_LOW_RESET = 16'd100;
    localparam logic [7:0]  LONG_RESET      = 8'd4;
    localparam logic [7:0]  SHORT_RESET     = 8'd2;

    // Last bit of a byte
    localparam logic [2:0] LAST_BIT = 3'd7;

    // Line phase, one-hot
    typedef enum logic [4:0] {
        PH_IDLE     = 5'b00001,
        PH_START    = 5'b00010,
        PH_BIT_HIGH = 5'b00100,
        PH_BIT_LOW  = 5'b01000,
        PH_HOLD     = 5'b10000
    } phase_t;

    // One classified input transaction
    typedef struct packed {
        logic       is_load;
        logic [7:0] data_byte;
        logic       first_of_frame;
        logic       last_of_frame;
    } item_t;

    // Queue head as seen by the back end
    typedef struct packed {
        logic  valid;
        item_t item;
    } head_t;

    // One result transaction
    typedef struct packed {
        logic line_level;
        logic line_driven;
        logic busy_res;
        logic accepted;
        logic byte_done;
    } result_t;

endpackage

// File: rtl/core/pwt_front.sv
`timescale 1ns / 1ps

module pwt_front
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  logic           kind,
    input  logic [7:0]     data_byte,
    input  logic           first_of_frame,
    input  logic           last_of_frame,
    output pwt_pkg::head_t head,
    input  logic           pop
);
    import pwt_pkg::*;

    item_t       slot_reg [2];
    logic        wr_ptr_reg;
    logic        wr_ptr_next;
    logic        rd_ptr_reg;
    logic        rd_ptr_next;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;
    logic        push;
    logic        do_pop;
    item_t       item_in;

    // Classify incoming transaction
    always_comb
    begin
        item_in.is_load        = (kind == KIND_LOAD);
        item_in.data_byte      = data_byte;
        item_in.first_of_frame = first_of_frame;
        item_in.last_of_frame  = last_of_frame;
    end

    assign in_stall   = (count_reg == 2'd2);
    assign push       = in_valid && !in_stall;
    assign do_pop     = pop && (count_reg != 2'd0);
    assign head.valid = (count_reg != 2'd0);
    assign head.item  = slot_reg[rd_ptr_reg];

    // Pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= item_in;
        end
    end

endmodule

// File: rtl/core/pwt_back.sv
`timescale 1ns / 1ps

module pwt_back
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  pwt_pkg::head_t                 head,
    output logic                           pop,
    input  logic                           cfg_write,
    input  logic [pwt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [15:0]                    cfg_data,
    output logic                           out_valid,
    input  logic                           out_stall,
    output pwt_pkg::result_t               result
);
    import pwt_pkg::*;

    // Timing registers
    logic [15:0] start_low_reg;
    logic [7:0]  long_reg;
    logic [7:0]  short_reg;

    // Line state
    phase_t      phase_reg;
    phase_t      phase_next;
    logic [15:0] ticks_reg;
    logic [15:0] ticks_next;
    logic [2:0]  bitpos_reg;
    logic [2:0]  bitpos_next;
    logic [7:0]  shift_reg;
    logic [7:0]  shift_next;
    logic        release_reg;
    logic        release_next;
    logic        drive_reg;
    logic        drive_next;
    logic        level_reg;
    logic        level_next;

    // Output register
    logic        out_valid_reg;
    result_t     result_reg;
    result_t     result_next;

    logic        busy;
    logic        accepted;
    logic        done;
    logic        cur_bit;
    logic        nxt_bit;
    logic [2:0]  bitpos_inc;
    logic [15:0] long_ext;
    logic [15:0] short_ext;

    assign busy       = (phase_reg == PH_START) || (phase_reg == PH_BIT_HIGH)
                        || (phase_reg == PH_BIT_LOW);
    assign pop        = head.valid && (!out_valid_reg || !out_stall);
    assign cur_bit    = shift_reg[bitpos_reg];
    assign bitpos_inc = bitpos_reg + 3'd1;
    assign nxt_bit    = shift_reg[bitpos_inc];
    assign long_ext   = {8'd0, long_reg};
    assign short_ext  = {8'd0, short_reg};

    // Timing register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_low_reg <= START_LOW_RESET;
            long_reg      <= LONG_RESET;
            short_reg     <= SHORT_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_START_LOW: start_low_reg <= cfg_data;
                CFG_LONG:      long_reg      <= cfg_data[7:0];
                CFG_SHORT:     short_reg     <= cfg_data[7:0];
                default:       ;
            endcase
        end
    end

    // Execute one transaction
    always_comb
    begin
        phase_next   = phase_reg;
        ticks_next   = ticks_reg;
        bitpos_next  = bitpos_reg;
        shift_next   = shift_reg;
        release_next = release_reg;
        drive_next   = drive_reg;
        level_next   = level_reg;
        accepted     = 1'b0;
        done         = 1'b0;

        if (head.item.is_load)
        begin
            if (!busy)
            begin
                accepted     = 1'b1;
                shift_next   = head.item.data_byte;
                bitpos_next  = 3'd0;
                release_next = head.item.last_of_frame;
                drive_next   = 1'b1;
                if (head.item.first_of_frame)
                begin
                    phase_next = PH_START;
                    level_next = 1'b0;
                    ticks_next = start_low_reg;
                end
                else
                begin
                    phase_next = PH_BIT_HIGH;
                    level_next = 1'b1;
                    ticks_next = head.item.data_byte[0] ? long_ext : short_ext;
                end
            end
        end
        else if (busy)
        begin
            if (ticks_reg > 16'd1)
            begin
                ticks_next = ticks_reg - 16'd1;
            end
            else
            begin
                case (phase_reg)
                    PH_START:
                    begin
                        phase_next = PH_BIT_HIGH;
                        level_next = 1'b1;
                        ticks_next = cur_bit ? long_ext : short_ext;
                    end
                    PH_BIT_HIGH:
                    begin
                        phase_next = PH_BIT_LOW;
                        level_next = 1'b0;
                        ticks_next = cur_bit ? short_ext : long_ext;
                    end
                    default:
                    begin
                        if (bitpos_reg == LAST_BIT)
                        begin
                            done       = 1'b1;
                            level_next = 1'b1;
                            ticks_next = 16'd0;
                            if (release_reg)
                            begin
                                drive_next = 1'b0;
                                phase_next = PH_IDLE;
                            end
                            else
                            begin
                                phase_next = PH_HOLD;
                            end
                        end
                        else
                        begin
                            bitpos_next = bitpos_inc;
                            phase_next  = PH_BIT_HIGH;
                            level_next  = 1'b1;
                            ticks_next  = nxt_bit ? long_ext : short_ext;
                        end
                    end
                endcase
            end
        end

        result_next.line_level  = drive_next ? level_next : 1'b1;
        result_next.line_driven = drive_next;
        result_next.busy_res    = (phase_next == PH_START) || (phase_next == PH_BIT_HIGH)
                                  || (phase_next == PH_BIT_LOW);
        result_next.accepted    = accepted;
        result_next.byte_done   = done;
    end

    // State and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            ticks_reg     <= 16'd0;
            bitpos_reg    <= 3'd0;
            shift_reg     <= 8'd0;
            release_reg   <= 1'b0;
            drive_reg     <= 1'b0;
            level_reg     <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                phase_reg   <= phase_next;
                ticks_reg   <= ticks_next;
                bitpos_reg  <= bitpos_next;
                shift_reg   <= shift_next;
                release_reg <= release_next;
                drive_reg   <= drive_next;
                level_reg   <= level_next;
            end
            if (pop)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign result    = result_reg;

endmodule

// File: rtl/core/pulse_width_single_wire_transmitter_top.sv
// A transaction is stored in the queue, then executed into the back end's result register.
// One transaction per cycle while the result is not stalled; the back end executes the queue head.
// A two-entry queue lets the input side keep accepting while a result waits.
// Reset: queue empty, line released and reading high, timing registers 100/4/2.
`timescale 1ns / 1ps

module pulse_width_single_wire_transmitter_top
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic                           kind,
    input  logic [7:0]                     data_byte,
    input  logic                           first_of_frame,
    input  logic                           last_of_frame,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [pwt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [15:0]                    cfg_data,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic                           line_level,
    output logic                           line_driven,
    output logic                           busy_res,
    output logic                           accepted,
    output logic                           byte_done
);
    import pwt_pkg::*;

    head_t   head;
    logic    pop;
    result_t result;

    // Configuration is always taken
    assign cfg_ready = 1'b1;

    pwt_front u_front
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .kind           (kind),
        .data_byte      (data_byte),
        .first_of_frame (first_of_frame),
        .last_of_frame  (last_of_frame),
        .head           (head),
        .pop            (pop)
    );

    pwt_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .pop       (pop),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .result    (result)
    );

    assign line_level  = result.line_level;
    assign line_driven = result.line_driven;
    assign busy_res    = result.busy_res;
    assign accepted    = result.accepted;
    assign byte_done   = result.byte_done;

endmodule

// File: rtl/core/pwt_checker.sv
`timescale 1ns / 1ps
`include "pulse_width_single_wire_transmitter_top_macros.svh"

module pwt_checker
(
    input logic clk,
    input logic rst_n,
    input logic out_valid,
    input logic out_stall,
    input logic line_level,
    input logic line_driven,
    input logic busy_res,
    input logic accepted,
    input logic byte_done
);

    // A stalled result transaction stays offered
    `PWT_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result dropped while stalled")

    // A released line reads high through the pull-up
    `PWT_ASSERT_SAME(a_released_high, out_valid && !line_driven, line_level, "released line low")

    // A taken load starts driving and is busy
    `PWT_ASSERT_SAME(a_load_busy, out_valid && accepted, line_driven && busy_res && !byte_done,
                     "accepted load not busy")

    // The end of a byte leaves the line high and not busy
    `PWT_ASSERT_SAME(a_done_high, out_valid && byte_done, line_level && !busy_res && !accepted,
                     "byte end inconsistent")

endmodule

bind pulse_width_single_wire_transmitter_top pwt_checker u_pwt_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .line_level  (line_level),
    .line_driven (line_driven),
    .busy_res    (busy_res),
    .accepted    (accepted),
    .byte_done   (byte_done)
);
